// File: rtl/core/overwriting_byte_ring_buffer_core_macros.svh
// Assertion macros for the overwriting byte ring buffer core.
// Expects signals named clk and arst_n in the scope where a macro is used.
`ifndef OVERWRITING_BYTE_RING_BUFFER_CORE_MACROS_SVH
`define OVERWRITING_BYTE_RING_BUFFER_CORE_MACROS_SVH

// Property checked on every rising edge outside reset.
`define OBRB_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Condition that must never hold outside reset.
`define OBRB_ASSERT_NEVER(lbl, cond, msg) \
	`OBRB_ASSERT(lbl, !(cond), msg)

`endif

// File: rtl/core/obrb_pkg.sv
// Shared types and constants of the overwriting byte ring buffer core.
// No dependencies; used by the interfaces, controller, datapath and top level.
`default_nettype none

package obrb_pkg;

	localparam int FUNC_W = 3;
	localparam int DATA_W = 8;
	localparam int AMT_W  = 6;

	typedef enum logic [FUNC_W-1:0] {
		F_PUT      = 3'd0,
		F_DROP     = 3'd1,
		F_READ_AT  = 3'd2,
		F_READ_NEW = 3'd3,
		F_CLEAR    = 3'd4
	} func_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load_in;
		logic exec_op;
		logic issue_rd;
		logic emit_rd;
	} obrb_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic stream;
		logic rd_last;
	} obrb_sts_t;

endpackage

`default_nettype wire

// File: rtl/core/obrb_in_if.sv
// Input channel of the ring buffer: valid/ready handshake with the operation word.
// Depends on obrb_pkg for the field widths.
`default_nettype none

interface obrb_in_if;
	import obrb_pkg::*;

	logic              valid;
	logic              ready;
	logic [FUNC_W-1:0] func;
	logic [DATA_W-1:0] value;
	logic [AMT_W-1:0]  amount;

	modport source (output valid, output func, output value, output amount, input ready);
	modport sink   (input valid, input func, input value, input amount, output ready);
endinterface

`default_nettype wire

// File: rtl/core/obrb_out_if.sv
// Output channel of the ring buffer: valid/ready handshake with the result word.
// Depends on obrb_pkg for the field widths.
`default_nettype none

interface obrb_out_if;
	import obrb_pkg::*;

	logic              valid;
	logic              ready;
	logic [DATA_W-1:0] data;
	logic              status;
	logic [AMT_W-1:0]  length;
	logic              last;

	modport source (output valid, output data, output status, output length, output last,
		input ready);
	modport sink   (input valid, input data, input status, input length, input last,
		output ready);
endinterface

`default_nettype wire

// File: rtl/core/obrb_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module obrb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

`default_nettype wire

// File: rtl/core/obrb_ctrl.sv
// Controller of the ring buffer: sequences load, execute and read streaming.
// Depends on obrb_pkg for the command and status structs.
`default_nettype none

module obrb_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic                out_ready,
	output logic                     out_valid,
	input  wire obrb_pkg::obrb_sts_t sts,
	output obrb_pkg::obrb_cmd_t      cmd
);
	import obrb_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_EXEC = 3'b010,
		S_READ = 3'b100
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;

	// The output register can take a word when empty or when its word leaves now.
	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d     = S_EXEC;
				end
			end
			S_EXEC: begin
				if (sts.stream) begin
					cmd.issue_rd = 1'b1;
					state_d      = S_READ;
				end else if (out_free) begin
					cmd.exec_op = 1'b1;
					state_d     = S_IDLE;
				end
			end
			S_READ: begin
				if (out_free) begin
					cmd.emit_rd = 1'b1;
					if (sts.rd_last) begin
						state_d = S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.exec_op || cmd.emit_rd) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
endmodule

`default_nettype wire

// File: rtl/core/obrb_dp.sv
// Datapath of the ring buffer: pointers, count, byte store and result register.
// Depends on obrb_pkg and obrb_ram.
`default_nettype none

module obrb_dp #(
	parameter int DEPTH = 64
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire obrb_pkg::obrb_cmd_t           cmd,
	input  wire logic [obrb_pkg::FUNC_W-1:0]   in_func,
	input  wire logic [obrb_pkg::DATA_W-1:0]   in_value,
	input  wire logic [obrb_pkg::AMT_W-1:0]    in_amount,
	output obrb_pkg::obrb_sts_t                sts,
	output logic      [obrb_pkg::DATA_W-1:0]   out_data,
	output logic                               out_status,
	output logic      [obrb_pkg::AMT_W-1:0]    out_length,
	output logic                               out_last
);
	import obrb_pkg::*;

	localparam int               IDX_W    = $clog2(DEPTH);
	localparam logic [IDX_W:0]   DEPTH_V  = (IDX_W+1)'(DEPTH);
	localparam logic [IDX_W-1:0] CNT_FULL = IDX_W'(DEPTH - 1);

	logic [FUNC_W-1:0] func_q;
	logic [DATA_W-1:0] value_q;
	logic [AMT_W-1:0]  amount_q;
	logic [IDX_W-1:0]  head_q, tail_q, count_q;
	logic [IDX_W-1:0]  head_d, tail_d, count_d;
	logic [IDX_W-1:0]  ptr_q;
	logic [AMT_W-1:0]  rem_q;
	logic [DATA_W-1:0] data_q;
	logic              status_q;
	logic [AMT_W-1:0]  length_q;
	logic              last_q;

	logic [IDX_W-1:0]  amt_i;
	logic [AMT_W-1:0]  cnt_ext;
	logic              drop_err, idx_err, err;
	logic [IDX_W-1:0]  first_addr, rd_addr;
	logic              ram_we, ram_re;
	logic [DATA_W-1:0] ram_rdata;

	function automatic logic [IDX_W-1:0] mod_add(input logic [IDX_W-1:0] a,
		input logic [IDX_W-1:0] b);
		logic [IDX_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= DEPTH_V) begin
			s = s - DEPTH_V;
		end
		return s[IDX_W-1:0];
	endfunction

	function automatic logic [IDX_W-1:0] mod_sub(input logic [IDX_W-1:0] a,
		input logic [IDX_W-1:0] b);
		logic [IDX_W:0] s;
		if (a >= b) begin
			s = {1'b0, a} - {1'b0, b};
		end else begin
			s = {1'b0, a} + DEPTH_V - {1'b0, b};
		end
		return s[IDX_W-1:0];
	endfunction

	// Whenever the amount is used as an index it is below DEPTH, so the low bits suffice.
	assign amt_i    = amount_q[IDX_W-1:0];
	assign cnt_ext  = AMT_W'(count_q);
	assign drop_err = amount_q > cnt_ext;
	assign idx_err  = amount_q >= cnt_ext;

	always_comb begin
		head_d      = head_q;
		tail_d      = tail_q;
		count_d     = count_q;
		err         = 1'b0;
		sts.stream  = 1'b0;
		sts.rd_last = (rem_q == AMT_W'(1));
		first_addr  = mod_add(head_q, amt_i);
		case (func_q)
			F_PUT: begin
				// A full buffer loses its oldest byte to make room.
				tail_d = mod_add(tail_q, IDX_W'(1));
				if (count_q == CNT_FULL) begin
					head_d = mod_add(head_q, IDX_W'(1));
				end else begin
					count_d = count_q + IDX_W'(1);
				end
			end
			F_DROP: begin
				err = drop_err;
				if (!drop_err) begin
					head_d  = mod_add(head_q, amt_i);
					count_d = count_q - amt_i;
				end
			end
			F_READ_AT: begin
				err        = idx_err;
				sts.stream = !idx_err;
			end
			F_READ_NEW: begin
				err        = drop_err;
				first_addr = mod_sub(tail_q, amt_i);
				sts.stream = !drop_err && (amount_q != '0);
			end
			F_CLEAR: begin
				head_d  = '0;
				tail_d  = '0;
				count_d = '0;
			end
			default: begin
			end
		endcase
	end

	assign ram_we  = cmd.exec_op && (func_q == F_PUT);
	assign ram_re  = cmd.issue_rd || cmd.emit_rd;
	assign rd_addr = cmd.issue_rd ? first_addr : ptr_q;

	obrb_ram #(
		.WIDTH (DATA_W),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (tail_q),
		.wdata (value_q),
		.re    (ram_re),
		.raddr (rd_addr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
			rem_q   <= '0;
		end else begin
			if (cmd.exec_op) begin
				head_q  <= head_d;
				tail_q  <= tail_d;
				count_q <= count_d;
			end
			if (cmd.issue_rd) begin
				rem_q <= (func_q == F_READ_AT) ? AMT_W'(1) : amount_q;
			end else if (cmd.emit_rd) begin
				rem_q <= rem_q - AMT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			func_q   <= in_func;
			value_q  <= in_value;
			amount_q <= in_amount;
		end
		// The read pointer runs one slot ahead of the byte held at the store's read port.
		if (ram_re) begin
			ptr_q <= mod_add(rd_addr, IDX_W'(1));
		end
		if (cmd.exec_op) begin
			data_q   <= '0;
			status_q <= err;
			length_q <= AMT_W'(count_d);
			last_q   <= 1'b1;
		end else if (cmd.emit_rd) begin
			data_q   <= ram_rdata;
			status_q <= 1'b0;
			length_q <= cnt_ext;
			last_q   <= sts.rd_last;
		end
	end

	assign out_data   = data_q;
	assign out_status = status_q;
	assign out_length = length_q;
	assign out_last   = last_q;
endmodule

`default_nettype wire

// File: rtl/core/overwriting_byte_ring_buffer_core.sv
// Top level of the overwriting byte ring buffer core.
// Depends on obrb_pkg, obrb_in_if, obrb_out_if, obrb_ctrl, obrb_dp and the macros header.
//
//  Channel   Direction  Word contents
//  in_ch     sink       func, value, amount
//  out_ch    source     data, status, length, last
//
// Put, drop, clear, failed reads, zero-length read newest and unused codes are accepted, then executed
// once the output register is free. Read at index and read newest N are accepted, issue the first store read,
// then emit their bytes; the single read port of the byte store streams one byte per cycle while the output is free.
// Reset clears head, tail and count; the store itself is not cleared and needs no pass.
// A stalled output holds its word; the next word is accepted while a result still waits.
`default_nettype none
`include "overwriting_byte_ring_buffer_core_macros.svh"

module overwriting_byte_ring_buffer_core #(
	parameter int DEPTH = 64
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	obrb_in_if.sink    in_ch,
	obrb_out_if.source out_ch
);
	import obrb_pkg::*;

	obrb_cmd_t cmd;
	obrb_sts_t sts;

	obrb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_ready (out_ch.ready),
		.out_valid (out_ch.valid),
		.sts       (sts),
		.cmd       (cmd)
	);

	obrb_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.in_func    (in_ch.func),
		.in_value   (in_ch.value),
		.in_amount  (in_ch.amount),
		.sts        (sts),
		.out_data   (out_ch.data),
		.out_status (out_ch.status),
		.out_length (out_ch.length),
		.out_last   (out_ch.last)
	);

	`OBRB_ASSERT(a_one_cmd, $onehot0({cmd.load_in, cmd.exec_op, cmd.issue_rd, cmd.emit_rd}), "more than one datapath command at once")
	`OBRB_ASSERT(a_busy_after_accept, (in_ch.valid && in_ch.ready) |=> !in_ch.ready, "input accepted again while an operation is in progress")
	`OBRB_ASSERT(a_busy_streaming, cmd.issue_rd |=> !in_ch.ready, "input accepted while a read stream is running")
	`OBRB_ASSERT_NEVER(a_len_range, out_ch.valid && (out_ch.length > 6'(DEPTH - 1)), "reported length exceeds capacity")
endmodule

`default_nettype wire

// File: tb/obrb_tb_pkg.sv
`timescale 1ns / 100ps
// Scoreboard for the overwriting byte ring buffer: predicts the result words of each
// accepted operation word and checks the words the block returns. Depends on obrb_pkg.
`default_nettype none

package obrb_tb_pkg;
	import obrb_pkg::*;

	localparam int RING_SLOTS = 64;

	localparam logic              STATUS_OK  = 1'b0;
	localparam logic              STATUS_ERR = 1'b1;
	localparam logic [FUNC_W-1:0] FUNC_SPARE_LO = 3'd5;
	localparam logic [FUNC_W-1:0] FUNC_SPARE_HI = 3'd7;

	typedef struct packed {
		logic [DATA_W-1:0] data;
		logic              status;
		logic [AMT_W-1:0]  length;
		logic              last;
	} result_word_t;

	class ring_buffer_tracker;
		logic [DATA_W-1:0] held_bytes [RING_SLOTS];
		logic [AMT_W-1:0]  head;
		logic [AMT_W-1:0]  tail;
		logic [AMT_W-1:0]  count;
		result_word_t      awaited[$];
		int unsigned       failures;

		function new();
			head = '0;
			tail = '0;
			count = '0;
			failures = 0;
			foreach (held_bytes[i]) held_bytes[i] = '0;
		endfunction

		function int unsigned outstanding();
			return awaited.size();
		endfunction

		// The length field always reports the count after the operation.
		function void queue_result(logic [DATA_W-1:0] data, logic status, logic last);
			result_word_t r;
			r.data = data;
			r.status = status;
			r.length = count;
			r.last = last;
			awaited.push_back(r);
		endfunction

		function void note_word(logic [FUNC_W-1:0] op, logic [DATA_W-1:0] value,
			logic [AMT_W-1:0] amount);
			int k;
			case (op)
				F_PUT: begin
					// A full buffer loses its oldest byte rather than refusing the put.
					if (count == AMT_W'(RING_SLOTS - 1)) head = head + 1'b1;
					else count = count + 1'b1;
					held_bytes[tail] = value;
					tail = tail + 1'b1;
					queue_result('0, STATUS_OK, 1'b1);
				end
				F_DROP: begin
					if (amount > count) begin
						queue_result('0, STATUS_ERR, 1'b1);
					end else begin
						head = head + amount;
						count = count - amount;
						queue_result('0, STATUS_OK, 1'b1);
					end
				end
				F_READ_AT: begin
					if (amount >= count) queue_result('0, STATUS_ERR, 1'b1);
					else queue_result(held_bytes[AMT_W'(head + amount)], STATUS_OK, 1'b1);
				end
				F_READ_NEW: begin
					if (amount > count) begin
						queue_result('0, STATUS_ERR, 1'b1);
					end else if (amount == '0) begin
						queue_result('0, STATUS_OK, 1'b1);
					end else begin
						for (k = 0; k < amount; k++)
							queue_result(held_bytes[AMT_W'(tail - amount + k)], STATUS_OK,
								k == amount - 1);
					end
				end
				F_CLEAR: begin
					head = '0;
					tail = '0;
					count = '0;
					queue_result('0, STATUS_OK, 1'b1);
				end
				default: begin
					queue_result('0, STATUS_OK, 1'b1);
				end
			endcase
		endfunction

		function void check_word(result_word_t got);
			result_word_t want;
			if (awaited.size() == 0) begin
				$error("result word with none expected: data %0d status %0d length %0d last %0d",
					got.data, got.status, got.length, got.last);
				failures++;
				return;
			end
			want = awaited.pop_front();
			if (got.data !== want.data) begin
				$error("data: expected %0d, got %0d", want.data, got.data);
				failures++;
			end
			if (got.status !== want.status) begin
				$error("status: expected %0d, got %0d", want.status, got.status);
				failures++;
			end
			if (got.length !== want.length) begin
				$error("length: expected %0d, got %0d", want.length, got.length);
				failures++;
			end
			if (got.last !== want.last) begin
				$error("last: expected %0d, got %0d", want.last, got.last);
				failures++;
			end
		endfunction
	endclass

endpackage

`default_nettype wire

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// Top of the ring buffer testbench: clock, reset, word drivers and the final verdict.
// Depends on obrb_pkg, obrb_in_if, obrb_out_if, obrb_tb_pkg and the block itself.
`default_nettype none

module tb_top;
	import obrb_pkg::*;
	import obrb_tb_pkg::*;

	localparam int DRAIN_TAIL = 8;
	localparam int HOLD_CYCLES = 300;
	localparam int PHASE_ITEMS = 60;

	logic clk;
	logic arst_n;

	obrb_in_if  in_ch();
	obrb_out_if out_ch();

	overwriting_byte_ring_buffer_core #(.DEPTH(RING_SLOTS)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	ring_buffer_tracker tracker = new();

	int unsigned sender_idle_pct = 0;
	int unsigned receiver_stall_pct = 0;
	int unsigned hold_off = 0;
	int unsigned phase_idle[4] = '{0, 45, 0, 16};
	int unsigned phase_stall[4] = '{0, 0, 45, 16};

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#4_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	// Receiver: a pending hold-off takes precedence over the random stalls.
	initial begin
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off > 0) begin
				out_ch.ready <= 1'b0;
				hold_off--;
			end else begin
				out_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1)
				tracker.note_word(in_ch.func, in_ch.value, in_ch.amount);
			if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
				tracker.check_word({out_ch.data, out_ch.status, out_ch.length, out_ch.last});
		end
	end

	// Called at a falling edge; returns at the falling edge after the word is taken.
	task automatic send_word(input logic [FUNC_W-1:0] op, input logic [DATA_W-1:0] value,
		input logic [AMT_W-1:0] amount);
		int unsigned gap;
		gap = 0;
		if ($urandom_range(99) < sender_idle_pct) gap = $urandom_range(4, 1);
		if (gap != 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_ch.valid  <= 1'b1;
		in_ch.func   <= op;
		in_ch.value  <= value;
		in_ch.amount <= amount;
		@(posedge clk);
		while (in_ch.ready !== 1'b1) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		in_ch.valid <= 1'b0;
		while (tracker.outstanding() != 0) @(negedge clk);
		repeat (DRAIN_TAIL) @(negedge clk);
	endtask

	// Mostly in-range amounts so that reads and drops succeed; a share stays fully random.
	task automatic send_random_word();
		int unsigned pick;
		int unsigned held;
		logic        wild;
		logic [FUNC_W-1:0] op;
		logic [AMT_W-1:0]  amount;
		pick = $urandom_range(99);
		held = tracker.count;
		wild = ($urandom_range(99) < 15);
		amount = AMT_W'($urandom_range(63));
		if (pick < 48) begin
			op = F_PUT;
		end else if (pick < 58) begin
			op = F_DROP;
			if (!wild) amount = AMT_W'(($urandom_range(3) == 0) ? held
				: $urandom_range(held > 6 ? 6 : held));
		end else if (pick < 76) begin
			op = F_READ_AT;
			if (!wild && held > 0) amount = AMT_W'($urandom_range(held - 1));
		end else if (pick < 92) begin
			op = F_READ_NEW;
			if (!wild) amount = AMT_W'(($urandom_range(9) == 0) ? held
				: $urandom_range(held > 12 ? 12 : held));
		end else if (pick < 95) begin
			op = F_CLEAR;
		end else begin
			op = FUNC_W'($urandom_range(FUNC_SPARE_HI, FUNC_SPARE_LO));
		end
		send_word(op, DATA_W'($urandom_range(255)), amount);
	endtask

	initial begin
		int i;
		int p;
		in_ch.valid  = 1'b0;
		in_ch.func   = F_PUT;
		in_ch.value  = '0;
		in_ch.amount = '0;
		arst_n = 1'b0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		// Empty buffer: read at index, non-zero drop and non-zero read newest fail.
		send_word(F_READ_AT, 8'h00, 6'd0);
		send_word(F_DROP, 8'h00, 6'd0);
		send_word(F_DROP, 8'h00, 6'd63);
		send_word(F_READ_NEW, 8'h00, 6'd0);
		send_word(F_READ_NEW, 8'h00, 6'd1);
		send_word(F_PUT, 8'h00, 6'd0);
		send_word(F_PUT, 8'hFF, 6'd63);
		send_word(F_PUT, 8'h5A, 6'd0);
		send_word(F_READ_AT, 8'h00, 6'd0);
		send_word(F_READ_AT, 8'h00, 6'd2);
		send_word(F_READ_AT, 8'h00, 6'd3);
		send_word(F_READ_NEW, 8'h00, 6'd3);
		send_word(F_READ_NEW, 8'h00, 6'd4);
		send_word(F_DROP, 8'h00, 6'd1);
		send_word(FUNC_SPARE_LO, 8'hFF, 6'd63);
		send_word(FUNC_SPARE_HI, 8'h00, 6'd0);
		send_word(F_CLEAR, 8'h00, 6'd0);
		send_word(F_READ_AT, 8'h00, 6'd0);
		send_word(F_PUT, 8'hA5, 6'd0);
		send_word(F_DROP, 8'h00, 6'd1);
		wait_drained();

		// Overfill while the receiver holds off, so the block backs up and stalls its input.
		hold_off = HOLD_CYCLES;
		for (i = 0; i < 70; i++)
			send_word(F_PUT, DATA_W'($urandom_range(255)), AMT_W'($urandom_range(63)));
		send_word(F_READ_NEW, 8'h00, 6'd63);
		send_word(F_READ_AT, 8'h00, 6'd62);
		send_word(F_READ_AT, 8'h00, 6'd63);
		send_word(F_DROP, 8'h00, 6'd63);
		send_word(F_READ_NEW, 8'h00, 6'd0);
		wait_drained();

		for (p = 0; p < 4; p++) begin
			sender_idle_pct = phase_idle[p];
			receiver_stall_pct = phase_stall[p];
			for (i = 0; i < PHASE_ITEMS; i++) send_random_word();
			wait_drained();
		end

		if (tracker.failures == 0 && tracker.outstanding() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

`default_nettype wire
